// ----- src/sector_readahead_cache_policy_macros.svh -----
// assertion macros for the sector readahead cache policy block
// used by the top level; expects clk and rst in scope at the point of use
`ifndef SECTOR_READAHEAD_CACHE_POLICY_MACROS_SVH
`define SECTOR_READAHEAD_CACHE_POLICY_MACROS_SVH
`ifndef SYNTH
`define SRAC_ASSERT_IMP(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("srac check failed");
`define SRAC_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("srac check failed");
`else
`define SRAC_ASSERT_IMP(name, cond, prop)
`define SRAC_ASSERT_NEXT(name, cond, prop)
`endif
`endif

// ----- src/srac_pkg.sv -----
// types and constants for the sector readahead cache policy
// no dependencies

package srac_pkg;

  localparam int SECTOR_W = 31;
  localparam int SLOT_W   = 5;
  localparam int COUNT_W  = 6;
  localparam int THR_W    = 8;
  localparam int RUN_W    = 32;

  localparam int SMALL_WINDOW = 8;
  localparam int LARGE_WINDOW = 32;
  localparam int BUF_CAP      = 32;
  localparam int SMALL_EFF = (SMALL_WINDOW > BUF_CAP) ? BUF_CAP :
                             ((SMALL_WINDOW < 1) ? 1 : SMALL_WINDOW);
  localparam int LARGE_EFF = (LARGE_WINDOW > BUF_CAP) ? BUF_CAP :
                             ((LARGE_WINDOW < 1) ? 1 : LARGE_WINDOW);
  localparam logic [COUNT_W-1:0] SMALL_COUNT = 6'(SMALL_EFF);
  localparam logic [COUNT_W-1:0] LARGE_COUNT = 6'(LARGE_EFF);

  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = 2;

  localparam logic [THR_W-1:0] SEQ_THRESHOLD_RESET = 8'd4;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_FILL    = 3'd1,
    ST_SERVED  = 3'd2,
    ST_DIRECT  = 3'd3,
    ST_IGNORED = 3'd4
  } status_t;

  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_DONE = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [SECTOR_W-1:0] sector;
    logic                fill_ok;
    logic [SLOT_W-1:0]   rem;
  } item_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] fill_start;
    logic [COUNT_W-1:0]  fill_count;
  } result_t;

  typedef struct packed {
    logic fill_pending;
    logic fill_issued;
  } back_stat_t;

endpackage

// ----- src/srac_front.sv -----
// front end: accepts words and registers them with the sector remainder
// modulo the small window; depends on srac_pkg

module srac_front
  import srac_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  kind_t               in_kind,
  input  logic [SECTOR_W-1:0] in_sector,
  input  logic                in_fill_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output item_t               out_item
);

  logic  v;
  item_t stg;
  item_t stg_next;
  logic  acc;

  assign acc = !v || out_ready;

  always_comb begin
    stg_next.kind    = in_kind;
    stg_next.sector  = in_sector;
    stg_next.fill_ok = in_fill_ok;
    stg_next.rem     = SLOT_W'(in_sector % SECTOR_W'(SMALL_EFF));
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      stg <= stg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (acc) begin
      v <= in_valid;
    end
  end

  assign in_ready  = acc;
  assign out_valid = v;
  assign out_item  = stg;

endmodule

// ----- src/srac_queue.sv -----
// short queue of classified words between front and back end
// depends on srac_pkg

module srac_queue
  import srac_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  item_t             entries[QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign in_ready  = count != (QPTR_W + 1)'(QDEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/srac_back.sv -----
// back end: window, sequence tracking and pending fill state, decision logic
// and the output register; depends on srac_pkg

module srac_back
  import srac_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  item_t            in_item,
  input  logic [THR_W-1:0] seq_threshold,
  output logic             out_valid,
  input  logic             out_ready,
  output result_t          out_result,
  output back_stat_t       stat
);

  logic [SECTOR_W-1:0] window_base, window_base_next;
  logic [COUNT_W-1:0]  window_size, window_size_next;
  logic                window_valid, window_valid_next;
  logic [SECTOR_W-1:0] prev_sector, prev_sector_next;
  logic                prev_valid, prev_valid_next;
  logic [RUN_W-1:0]    run_length, run_length_next;
  logic                fill_pending, fill_pending_next;
  logic [SECTOR_W-1:0] pending_sector, pending_sector_next;
  logic [SECTOR_W-1:0] pending_start, pending_start_next;
  logic [COUNT_W-1:0]  pending_size, pending_size_next;

  logic                take;
  result_t             res;
  logic [SECTOR_W-1:0] serve_sec;
  logic                seq;
  logic [SECTOR_W-1:0] diff;
  logic                hit;
  logic                use_large;
  logic                do_serve;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  assign serve_sec = (in_item.kind == KIND_READ) ? in_item.sector : pending_sector;
  assign seq   = prev_valid && ({1'b0, serve_sec} == ({1'b0, prev_sector} + 32'd1));
  assign diff  = in_item.sector - window_base;
  assign hit   = window_valid && (in_item.sector >= window_base)
                 && (diff < SECTOR_W'(window_size));
  assign use_large = seq && (run_length >= RUN_W'(seq_threshold));

  always_comb begin
    res                 = '{status: ST_IGNORED, slot: '0, fill_start: '0, fill_count: '0};
    do_serve            = 1'b0;
    window_base_next    = window_base;
    window_size_next    = window_size;
    window_valid_next   = window_valid;
    fill_pending_next   = fill_pending;
    pending_sector_next = pending_sector;
    pending_start_next  = pending_start;
    pending_size_next   = pending_size;
    case (in_item.kind)
      KIND_READ: begin
        if (fill_pending) begin
          res.status = ST_IGNORED;
        end else if (hit) begin
          res.status = ST_HIT;
          res.slot   = diff[SLOT_W-1:0];
          do_serve   = 1'b1;
        end else begin
          res.status          = ST_FILL;
          res.fill_start      = use_large ? in_item.sector
                                          : in_item.sector - SECTOR_W'(in_item.rem);
          res.fill_count      = use_large ? LARGE_COUNT : SMALL_COUNT;
          fill_pending_next   = 1'b1;
          pending_sector_next = in_item.sector;
          pending_start_next  = res.fill_start;
          pending_size_next   = res.fill_count;
        end
      end
      KIND_DONE: begin
        if (!fill_pending) begin
          res.status = ST_IGNORED;
        end else if (in_item.fill_ok) begin
          fill_pending_next = 1'b0;
          res.status        = ST_SERVED;
          res.slot          = SLOT_W'(pending_sector - pending_start);
          window_base_next  = pending_start;
          window_size_next  = pending_size;
          window_valid_next = 1'b1;
          do_serve          = 1'b1;
        end else begin
          fill_pending_next = 1'b0;
          res.status        = ST_DIRECT;
          res.fill_start    = pending_sector;
          res.fill_count    = COUNT_W'(1);
          window_valid_next = 1'b0;
        end
      end
      default: begin
        res.status = ST_IGNORED;
      end
    endcase
  end

  always_comb begin
    prev_sector_next = prev_sector;
    prev_valid_next  = prev_valid;
    run_length_next  = run_length;
    if (do_serve) begin
      prev_sector_next = serve_sec;
      prev_valid_next  = 1'b1;
      if (!seq) begin
        run_length_next = '0;
      end else if (run_length != '1) begin
        run_length_next = run_length + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_result     <= res;
      pending_sector <= pending_sector_next;
      pending_start  <= pending_start_next;
      pending_size   <= pending_size_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      window_base  <= '0;
      window_size  <= '0;
      window_valid <= 1'b0;
      prev_sector  <= '0;
      prev_valid   <= 1'b0;
      run_length   <= '0;
      fill_pending <= 1'b0;
    end else begin
      if (take) begin
        out_valid    <= 1'b1;
        window_base  <= window_base_next;
        window_size  <= window_size_next;
        window_valid <= window_valid_next;
        prev_sector  <= prev_sector_next;
        prev_valid   <= prev_valid_next;
        run_length   <= run_length_next;
        fill_pending <= fill_pending_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.fill_pending = fill_pending;
  assign stat.fill_issued  = take && (res.status == ST_FILL);

endmodule

// ----- src/sector_readahead_cache_policy.sv -----
// top level of the sector readahead cache policy: front, queue and back end
// depends on srac_pkg, srac_front, srac_queue, srac_back and the macros header
//
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tuser kind, s_tdata sector and fill_ok
// m_        out  m_tvalid/m_tready  m_tuser status, m_tdata slot, start, count
// cfg_      in   cfg_valid/cfg_ready cfg_data seq_threshold
//
// one word per cycle while m_ does not stall; a word accepted on s_ passes these
// registers before m_tvalid rises: the front register that takes the remainder modulo the
// small window, one queue slot and the back end output register
// rst is synchronous and clears all control state and the window tracking
// the four-entry queue lets the front keep accepting while m_ stalls

`include "sector_readahead_cache_policy_macros.svh"

module sector_readahead_cache_policy
  import srac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sector [30:0], fill_ok [31]
  input  logic        s_tuser,   // kind [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // slot [4:0], fill_start [35:5], fill_count [41:36]
  output logic [2:0]  m_tuser,   // status [2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [THR_W-1:0] seq_threshold;
  logic             f_valid, f_ready;
  item_t            f_item;
  logic             q_valid, q_ready;
  item_t            q_item;
  result_t          result;
  back_stat_t       stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_threshold <= SEQ_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      seq_threshold <= cfg_data;
    end
  end

  srac_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_kind    (kind_t'(s_tuser)),
    .in_sector  (s_tdata[30:0]),
    .in_fill_ok (s_tdata[31]),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .out_item   (f_item)
  );

  srac_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  srac_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (q_valid),
    .in_ready      (q_ready),
    .in_item       (q_item),
    .seq_threshold (seq_threshold),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_result    (result),
    .stat          (stat)
  );

  assign m_tuser = result.status;
  assign m_tdata = {6'b0, result.fill_count, result.fill_start, result.slot};

  // no fetch is asked for on hits, serves or ignored words
  `SRAC_ASSERT_IMP(a_no_fetch, m_tvalid && (m_tuser == ST_HIT || m_tuser == ST_SERVED || m_tuser == ST_IGNORED), m_tdata[41:5] == '0)
  // fallback always reads one sector
  `SRAC_ASSERT_IMP(a_direct_one, m_tvalid && m_tuser == ST_DIRECT, m_tdata[41:36] == 6'd1)
  // an issued fill leaves a fill outstanding
  `SRAC_ASSERT_NEXT(a_fill_pending, stat.fill_issued, stat.fill_pending)
  // a fill is only issued while none is outstanding
  `SRAC_ASSERT_IMP(a_fill_single, stat.fill_issued, !stat.fill_pending)

endmodule

// ----- verif/tb.sv -----
// self-checking testbench for sector_readahead_cache_policy
// needs srac_pkg and the block's rtl; no files, arguments or seeds are read
`timescale 1ns / 100ps

module tb;
  import srac_pkg::*;

  typedef struct {
    kind_t               kind;
    logic [SECTOR_W-1:0] sector;
    logic                ok;
    logic                typed;
    result_t             want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // sector [30:0], fill_ok [31]
  logic        s_tuser;   // kind [0]
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // slot [4:0], fill_start [35:5], fill_count [41:36]
  logic [2:0]  m_tuser;   // status [2:0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  // cache policy state as the testbench sees it
  logic [THR_W-1:0]    thr;
  logic [SECTOR_W-1:0] win_base;
  logic [COUNT_W-1:0]  win_size;
  logic                win_valid;
  logic [SECTOR_W-1:0] last_sector;
  logic                last_valid;
  logic [RUN_W-1:0]    seq_run;
  logic                fetch_busy;
  logic [SECTOR_W-1:0] fetch_sector;
  logic [SECTOR_W-1:0] fetch_start;
  logic [COUNT_W-1:0]  fetch_size;

  result_t   due_decisions[$];
  plan_row_t plan[$];
  int        mismatches = 0;
  int        words_in = 0;
  int        words_out = 0;
  int        status_seen[5] = '{0, 0, 0, 0, 0};
  int        large_fills = 0;
  bit        burst_s = 1'b0;
  bit        burst_m = 1'b0;

  sector_readahead_cache_policy dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic follows_last(logic [SECTOR_W-1:0] s);
    return last_valid && ({1'b0, s} == {1'b0, last_sector} + 32'd1);
  endfunction

  task automatic note_served(input logic [SECTOR_W-1:0] s);
    if (follows_last(s)) begin
      if (seq_run != '1) seq_run++;
    end else begin
      seq_run = '0;
    end
    last_sector = s;
    last_valid  = 1'b1;
  endtask

  task automatic predict_decision(input kind_t k, input logic [SECTOR_W-1:0] s,
                                  input logic ok, output result_t r);
    logic [SECTOR_W-1:0] off;
    r = '0;
    r.status = ST_IGNORED;
    if (k == KIND_READ) begin
      off = s - win_base;
      if (!fetch_busy) begin
        if (win_valid && s >= win_base && off < win_size) begin
          note_served(s);
          r.status = ST_HIT;
          r.slot   = off[SLOT_W-1:0];
        end else begin
          if (follows_last(s) && seq_run >= thr) begin
            fetch_start = s;
            fetch_size  = LARGE_COUNT;
          end else begin
            fetch_start = s - SECTOR_W'(s % SMALL_EFF);
            fetch_size  = SMALL_COUNT;
          end
          fetch_busy   = 1'b1;
          fetch_sector = s;
          r.status     = ST_FILL;
          r.fill_start = fetch_start;
          r.fill_count = fetch_size;
        end
      end
    end else if (fetch_busy) begin
      fetch_busy = 1'b0;
      if (ok) begin
        win_base  = fetch_start;
        win_size  = fetch_size;
        win_valid = 1'b1;
        note_served(fetch_sector);
        off      = fetch_sector - fetch_start;
        r.status = ST_SERVED;
        r.slot   = off[SLOT_W-1:0];
      end else begin
        win_valid    = 1'b0;
        r.status     = ST_DIRECT;
        r.fill_start = fetch_sector;
        r.fill_count = 6'd1;
      end
    end
  endtask

  task automatic send_word(input kind_t k, input logic [SECTOR_W-1:0] s, input logic ok,
                           output result_t r);
    int unsigned gap;
    gap = burst_s ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ok, s};
    s_tuser  <= k;
    do @(posedge clk); while (!s_tready);
    predict_decision(k, s, ok, r);
    words_in++;
    if ($urandom_range(0, 47) == 0) burst_s = !burst_s;
  endtask

  task automatic wait_drained();
    if (s_tvalid) s_tvalid <= 1'b0;
    do @(posedge clk); while (due_decisions.size() != 0);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thr = v;
  endtask

  task automatic add_row(input kind_t k, input logic [SECTOR_W-1:0] s, input logic ok,
                         input logic typed, input status_t st, input logic [SLOT_W-1:0] slot,
                         input logic [SECTOR_W-1:0] start, input logic [COUNT_W-1:0] cnt);
    plan_row_t row;
    row.kind   = k;
    row.sector = s;
    row.ok     = ok;
    row.typed  = typed;
    row.want   = '0;
    row.want.status     = st;
    row.want.slot       = slot;
    row.want.fill_start = start;
    row.want.fill_count = cnt;
    plan.push_back(row);
  endtask

  // mostly well-formed read / completion pairs, seq_pct steers toward sequential streams
  task automatic random_word(input int unsigned seq_pct);
    kind_t               k;
    logic [SECTOR_W-1:0] s;
    logic                ok;
    int unsigned         pick;
    result_t             r;
    s    = SECTOR_W'($urandom());
    ok   = 1'($urandom_range(0, 1));
    k    = KIND_READ;
    pick = $urandom_range(0, 99);
    if (fetch_busy) begin
      k  = (pick < 90) ? KIND_DONE : KIND_READ;
      ok = ($urandom_range(0, 9) != 0);
    end else if (pick < 6) begin
      k = KIND_DONE;
    end else begin
      pick = $urandom_range(0, 99);
      if (last_valid && pick < seq_pct) s = last_sector + 1'b1;
      else if (win_valid && pick < seq_pct + 15)
        s = win_base + SECTOR_W'($urandom_range(0, win_size));
      else if (pick < seq_pct + 25) s = SECTOR_W'('1) - SECTOR_W'($urandom_range(0, 40));
      else if (pick < seq_pct + 35) s = SECTOR_W'($urandom_range(0, 100));
    end
    send_word(k, s, ok, r);
    due_decisions.push_back(r);
    if ($urandom_range(0, 299) == 0) wait_drained();
  endtask

  task automatic run_phase(input logic [THR_W-1:0] t, input int count,
                           input int unsigned seq_pct);
    write_threshold(t);
    repeat (count) random_word(seq_pct);
  endtask

  initial begin
    result_t r;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;

    thr          = SEQ_THRESHOLD_RESET;
    win_base     = '0;
    win_size     = '0;
    win_valid    = 1'b0;
    last_sector  = '0;
    last_valid   = 1'b0;
    seq_run      = '0;
    fetch_busy   = 1'b0;
    fetch_sector = '0;
    fetch_start  = '0;
    fetch_size   = '0;

    add_row(KIND_READ, 31'd0, 1'b0, 1'b1, ST_FILL, 5'd0, 31'd0, 6'd8);
    add_row(KIND_DONE, 31'h7fffffff, 1'b1, 1'b1, ST_SERVED, 5'd0, 31'd0, 6'd0);
    add_row(KIND_READ, 31'd1, 1'b1, 1'b1, ST_HIT, 5'd1, 31'd0, 6'd0);
    add_row(KIND_READ, 31'd7, 1'b0, 1'b1, ST_HIT, 5'd7, 31'd0, 6'd0);
    add_row(KIND_READ, 31'd8, 1'b0, 1'b0, ST_IGNORED, 5'd0, 31'd0, 6'd0);
    add_row(KIND_READ, 31'd9, 1'b0, 1'b1, ST_IGNORED, 5'd0, 31'd0, 6'd0);
    add_row(KIND_DONE, 31'd0, 1'b0, 1'b1, ST_DIRECT, 5'd0, 31'd8, 6'd1);
    add_row(KIND_DONE, 31'd0, 1'b1, 1'b1, ST_IGNORED, 5'd0, 31'd0, 6'd0);
    add_row(KIND_READ, 31'h7fffffff, 1'b0, 1'b1, ST_FILL, 5'd0, 31'h7ffffff8, 6'd8);
    add_row(KIND_DONE, 31'd0, 1'b1, 1'b1, ST_SERVED, 5'd7, 31'd0, 6'd0);
    add_row(KIND_READ, 31'h7ffffff8, 1'b0, 1'b1, ST_HIT, 5'd0, 31'd0, 6'd0);
    add_row(KIND_READ, 31'd19, 1'b0, 1'b0, ST_IGNORED, 5'd0, 31'd0, 6'd0);
    add_row(KIND_DONE, 31'd0, 1'b1, 1'b0, ST_IGNORED, 5'd0, 31'd0, 6'd0);
    for (int i = 20; i <= 23; i++)
      add_row(KIND_READ, 31'(i), 1'b0, 1'b0, ST_IGNORED, 5'd0, 31'd0, 6'd0);
    // run length reaches the threshold here, so the next miss is a large fill
    add_row(KIND_READ, 31'd24, 1'b0, 1'b0, ST_IGNORED, 5'd0, 31'd0, 6'd0);
    add_row(KIND_DONE, 31'd0, 1'b1, 1'b0, ST_IGNORED, 5'd0, 31'd0, 6'd0);
    add_row(KIND_READ, 31'd55, 1'b0, 1'b0, ST_IGNORED, 5'd0, 31'd0, 6'd0);
    add_row(KIND_READ, 31'd56, 1'b0, 1'b0, ST_IGNORED, 5'd0, 31'd0, 6'd0);
    add_row(KIND_DONE, 31'd0, 1'b0, 1'b0, ST_IGNORED, 5'd0, 31'd0, 6'd0);
    add_row(KIND_READ, 31'd23, 1'b0, 1'b0, ST_IGNORED, 5'd0, 31'd0, 6'd0);
    add_row(KIND_DONE, 31'd0, 1'b1, 1'b0, ST_IGNORED, 5'd0, 31'd0, 6'd0);
    add_row(KIND_READ, 31'd24, 1'b0, 1'b0, ST_IGNORED, 5'd0, 31'd0, 6'd0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      send_word(plan[i].kind, plan[i].sector, plan[i].ok, r);
      due_decisions.push_back(plan[i].typed ? plan[i].want : r);
    end

    run_phase(8'd0, 200, 60);
    run_phase(8'd255, 450, 100);
    run_phase(8'd1, 150, 70);
    run_phase(8'($urandom_range(2, 254)), 250, 55);
    run_phase(8'd128, 150, 80);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("%0d words in, %0d decisions out, thresholds 4, 0, 255, 1, random and 128",
             words_in, words_out);
    $display("hit %0d, fill %0d (large %0d), served %0d, direct %0d, ignored %0d",
             status_seen[ST_HIT], status_seen[ST_FILL], large_fills, status_seen[ST_SERVED],
             status_seen[ST_DIRECT], status_seen[ST_IGNORED]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    result_t     want;
    m_tready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = burst_m ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      words_out++;
      if (m_tuser < 5) status_seen[m_tuser]++;
      if (m_tuser == ST_FILL && m_tdata[41:36] == LARGE_COUNT) large_fills++;
      if (due_decisions.size() == 0) begin
        $error("decision with none expected: status %0d", m_tuser);
        mismatches++;
      end else begin
        want = due_decisions.pop_front();
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_tuser);
          mismatches++;
        end
        if (m_tdata[4:0] !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, m_tdata[4:0]);
          mismatches++;
        end
        if (m_tdata[35:5] !== want.fill_start) begin
          $error("fill_start: expected %0h, actual %0h", want.fill_start, m_tdata[35:5]);
          mismatches++;
        end
        if (m_tdata[41:36] !== want.fill_count) begin
          $error("fill_count: expected %0d, actual %0d", want.fill_count, m_tdata[41:36]);
          mismatches++;
        end
      end
      if ($urandom_range(0, 47) == 0) burst_m = !burst_m;
    end
  end

  initial begin
    #(5_000_000);
    $display("timeout with %0d decisions outstanding", due_decisions.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/srac_pkg.sv
src/srac_front.sv
src/srac_queue.sv
src/srac_back.sv
src/sector_readahead_cache_policy.sv
verif/tb.sv
